/* rtl/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace unit.
package sfr_pkg;

    // Character and register geometry
    localparam int CHAR_BITS   = 8;
    localparam int REG_CHARS   = 8;
    localparam int CFG_DATA_W  = REG_CHARS * CHAR_BITS;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int POS_W       = $clog2(REG_CHARS);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LEN   = 2'd0,
        CFG_KEY_CHARS = 2'd1,
        CFG_REP_LEN   = 2'd2,
        CFG_REP_CHARS = 2'd3
    } cfg_index_t;

    // Input transaction
    typedef struct packed {
        logic [CHAR_BITS-1:0] in_char;
        logic                 char_present;
        logic                 string_end;
    } src_item_t;

    // Output transaction
    typedef struct packed {
        logic [CHAR_BITS-1:0] out_char;
        logic                 out_present;
        logic                 out_last;
    } dst_item_t;

    // Work handed from front to back: a run of characters, first one lowest
    typedef struct packed {
        logic [CFG_DATA_W-1:0] chars;
        logic [LEN_W-1:0]      count;
        logic                  last;
    } job_t;

endpackage

/* rtl/sfr_front.sv */
// Front end: configuration registers, match window and job classification.
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_KEY_CHARS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  src_item_t             item,
    input  logic                  accept,
    output job_t                  job,
    output logic                  push
);

    localparam int CNT_W = $clog2(MAX_KEY_CHARS + 1);

    logic [LEN_W-1:0]      key_length_reg;
    logic [CFG_DATA_W-1:0] key_chars_reg;
    logic [LEN_W-1:0]      rep_length_reg;
    logic [CFG_DATA_W-1:0] rep_chars_reg;

    logic [CHAR_BITS-1:0]  window_reg  [MAX_KEY_CHARS];
    logic [CHAR_BITS-1:0]  window_next [MAX_KEY_CHARS];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic [CHAR_BITS-1:0]  appended [MAX_KEY_CHARS];
    logic [CFG_DATA_W-1:0] appended_flat;
    logic [CFG_DATA_W-1:0] window_flat;
    logic [CNT_W-1:0]      cnt_plus;
    logic [CNT_W-1:0]      klen;
    logic [LEN_W-1:0]      rlen;
    logic                  key_hit;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= '0;
            key_chars_reg  <= '0;
            rep_length_reg <= '0;
            rep_chars_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY_LEN:   key_length_reg <= cfg_data[LEN_W-1:0];
                CFG_KEY_CHARS: key_chars_reg  <= cfg_data;
                CFG_REP_LEN:   rep_length_reg <= cfg_data[LEN_W-1:0];
                CFG_REP_CHARS: rep_chars_reg  <= cfg_data;
            endcase
        end
    end

    // Clamp oversized lengths to the window depth
    assign klen = (key_length_reg > LEN_W'(MAX_KEY_CHARS)) ? CNT_W'(MAX_KEY_CHARS)
                                                           : key_length_reg[CNT_W-1:0];
    assign rlen = (rep_length_reg > LEN_W'(MAX_KEY_CHARS)) ? LEN_W'(MAX_KEY_CHARS)
                                                           : rep_length_reg;
    assign cnt_plus = count_reg + CNT_W'(1);

    // Append the new character and compare the window against the key
    always_comb
    begin
        appended_flat = '0;
        window_flat   = '0;
        key_hit       = 1'b1;
        for (int i = 0; i < MAX_KEY_CHARS; i++)
        begin
            appended[i] = (CNT_W'(i) == count_reg) ? item.in_char : window_reg[i];
            appended_flat[i*CHAR_BITS +: CHAR_BITS] = appended[i];
            window_flat[i*CHAR_BITS +: CHAR_BITS]   = window_reg[i];
            if ((CNT_W'(i) < klen) &&
                (appended[i] != key_chars_reg[i*CHAR_BITS +: CHAR_BITS]))
            begin
                key_hit = 1'b0;
            end
        end
    end

    // Classify the transaction into a job and the next window
    // The window never holds a full key after a transaction, so appending
    // never needs room made first.
    always_comb
    begin
        job         = '0;
        job.last    = item.string_end;
        count_next  = count_reg;
        window_next = window_reg;
        if (item.char_present)
        begin
            window_next = appended;
            count_next  = '0;
            priority if (cnt_plus > klen)
            begin
                // key shorter than the window: pass everything through
                job.chars = appended_flat;
                job.count = LEN_W'(cnt_plus);
            end
            else if ((cnt_plus == klen) && key_hit)
            begin
                job.chars = rep_chars_reg;
                job.count = rlen;
            end
            else if (item.string_end)
            begin
                job.chars = appended_flat;
                job.count = LEN_W'(cnt_plus);
            end
            else if (cnt_plus == klen)
            begin
                // mismatch: release the oldest character, shift the rest down
                job.chars = appended_flat;
                job.count = LEN_W'(1);
                count_next = count_reg;
                for (int i = 0; i < MAX_KEY_CHARS - 1; i++)
                begin
                    window_next[i] = appended[i+1];
                end
            end
            else
            begin
                count_next = cnt_plus;
            end
        end
        else if (item.string_end)
        begin
            job.chars  = window_flat;
            job.count  = LEN_W'(count_reg);
            count_next = '0;
        end
    end

    assign push = accept && ((job.count != '0) || item.string_end);

    // Advance the window count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // Hold window characters
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg <= window_next;
        end
    end

endmodule

/* rtl/sfr_queue.sv */
// Small job queue between the front end and the back end.
module sfr_queue
    import sfr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/sfr_back.sv */
// Back end: plays each job out one character per cycle, while dst is not stalled, into the output register.
module sfr_back
    import sfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job_in,
    output logic      job_pop,
    output logic      dst_valid,
    input  logic      dst_stall,
    output dst_item_t dst_item
);

    logic                  active_reg;
    logic                  active_next;
    logic [CFG_DATA_W-1:0] chars_reg;
    logic [LEN_W-1:0]      count_reg;
    logic                  last_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    dst_item_t             out_item_reg;
    dst_item_t             out_item_next;
    logic                  slot_free;
    logic                  final_char;

    assign slot_free  = !out_valid_reg || !dst_stall;
    assign job_pop    = !active_reg && job_valid;
    assign final_char = ((LEN_W'(pos_reg) + LEN_W'(1)) == count_reg);

    // Emit the next result of the current job
    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
            if (active_reg)
            begin
                out_valid_next = 1'b1;
                if (count_reg == '0)
                begin
                    // end of string with nothing left: bare end marker
                    out_item_next.out_char    = '0;
                    out_item_next.out_present = 1'b0;
                    out_item_next.out_last    = 1'b1;
                    active_next               = 1'b0;
                end
                else
                begin
                    out_item_next.out_char    = chars_reg[pos_reg*CHAR_BITS +: CHAR_BITS];
                    out_item_next.out_present = 1'b1;
                    out_item_next.out_last    = last_reg && final_char;
                    pos_next                  = pos_reg + POS_W'(1);
                    if (final_char)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= job_pop ? 1'b1 : active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a job or step through it; hold the output payload
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (job_pop)
        begin
            chars_reg <= job_in.chars;
            count_reg <= job_in.count;
            last_reg  <= job_in.last;
            pos_reg   <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

endmodule

/* rtl/stream_find_and_replace_unit.sv */
// Top level of the stream find-and-replace unit: front end, job queue, back end.
//
//   channel  direction  handshake              payload
//   src      in         src_valid / src_stall  src_item  (in_char, char_present, string_end)
//   dst      out        dst_valid / dst_stall  dst_item  (out_char, out_present, out_last)
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front end takes one source transaction per cycle while the job queue has room.
// The back end loads a job only while it is idle and then emits that job's results in
// order; it takes no new job until the last result of the current one has been emitted.
// Reset clears the window count, the queue and the output valid; configuration is zero.
// A stall on dst holds the output register; the queue then fills and src_stall rises.
module stream_find_and_replace_unit
    import sfr_pkg::*;
#(
    parameter int MAX_KEY_CHARS = 8,
    parameter int QUEUE_DEPTH   = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  src_item_t             src_item,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    output dst_item_t             dst_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic src_accept;
    logic job_push;
    job_t job_front;
    logic queue_full;
    logic queue_has_job;
    job_t job_back;
    logic job_pop;

    assign cfg_ready  = 1'b1;
    assign src_stall  = queue_full;
    assign src_accept = src_valid && !src_stall;

    sfr_front #(
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (src_item),
        .accept    (src_accept),
        .job       (job_front),
        .push      (job_push)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (job_front),
        .full      (queue_full),
        .pop       (job_pop),
        .not_empty (queue_has_job),
        .pop_job   (job_back)
    );

    sfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_has_job),
        .job_in    (job_back),
        .job_pop   (job_pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule

/* dv/stream_find_and_replace_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for the stream find-and-replace unit: directed and random strings against a predictor.
module stream_find_and_replace_unit_tb;
    import sfr_pkg::*;

    localparam int DRAIN_CYCLES  = 32;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_CHARS   = 23;
    localparam int MAX_PRINTED   = 50;

    // Predict the rewritten string and compare it with what leaves the block
    class rewrite_scoreboard;
        logic [LEN_W-1:0]      key_len;
        logic [CFG_DATA_W-1:0] key_chars;
        logic [LEN_W-1:0]      rep_len;
        logic [CFG_DATA_W-1:0] rep_chars;
        logic [CHAR_BITS-1:0]  window [REG_CHARS];
        int unsigned           window_fill;
        dst_item_t             step_out [2*REG_CHARS];
        int unsigned           step_n;
        dst_item_t             rewritten_queue [$];
        int unsigned           errors;

        function new();
            key_len     = '0;
            key_chars   = '0;
            rep_len     = '0;
            rep_chars   = '0;
            window_fill = 0;
            step_n      = 0;
            errors      = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_KEY_LEN:   key_len   = data[LEN_W-1:0];
                CFG_KEY_CHARS: key_chars = data;
                CFG_REP_LEN:   rep_len   = data[LEN_W-1:0];
                CFG_REP_CHARS: rep_chars = data;
                default: ;
            endcase
        endfunction

        function void emit(logic [CHAR_BITS-1:0] ch, logic present);
            dst_item_t res;
            res.out_char    = present ? ch : '0;
            res.out_present = present;
            res.out_last    = 1'b0;
            step_out[step_n] = res;
            step_n++;
        endfunction

        function void flush_window();
            for (int i = 0; i < window_fill; i++)
                emit(window[i], 1'b1);
            window_fill = 0;
        endfunction

        // Work out every output character caused by one source transaction
        function void take_source(src_item_t txn);
            int unsigned klen;
            int unsigned rlen;
            logic        hit;
            dst_item_t   tail;
            klen   = (key_len > REG_CHARS) ? REG_CHARS : key_len;
            rlen   = (rep_len > REG_CHARS) ? REG_CHARS : rep_len;
            step_n = 0;
            // drop idle steps
            if (!txn.char_present && !txn.string_end)
                return;
            if (txn.char_present)
            begin
                if (window_fill >= REG_CHARS)
                    flush_window();
                window[window_fill] = txn.in_char;
                window_fill++;
                // key shrank under a partly filled window: pass everything through
                if (window_fill > klen)
                    flush_window();
                else if (window_fill == klen)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < klen; i++)
                        if (window[i] != key_chars[i*CHAR_BITS +: CHAR_BITS])
                            hit = 1'b0;
                    if (hit)
                    begin
                        for (int i = 0; i < rlen; i++)
                            emit(rep_chars[i*CHAR_BITS +: CHAR_BITS], 1'b1);
                        window_fill = 0;
                    end
                    else
                    begin
                        // release the oldest character and shift the rest down
                        emit(window[0], 1'b1);
                        for (int i = 1; i < window_fill; i++)
                            window[i-1] = window[i];
                        window_fill--;
                    end
                end
            end
            if (txn.string_end)
            begin
                flush_window();
                if (step_n == 0)
                    emit('0, 1'b0);
                tail = step_out[step_n-1];
                tail.out_last = 1'b1;
                step_out[step_n-1] = tail;
            end
            for (int i = 0; i < step_n; i++)
                rewritten_queue.push_back(step_out[i]);
        endfunction

        // Print one line per mismatch, up to a cap, and count all of them
        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_rewrite(dst_item_t got);
            dst_item_t want;
            if (rewritten_queue.size() == 0)
            begin
                report($sformatf("unexpected output char=%02h present=%0b last=%0b",
                                 got.out_char, got.out_present, got.out_last));
                return;
            end
            want = rewritten_queue.pop_front();
            if (got.out_char !== want.out_char)
                report($sformatf("out_char got %02h want %02h", got.out_char, want.out_char));
            if (got.out_present !== want.out_present)
                report($sformatf("out_present got %0b want %0b",
                                 got.out_present, want.out_present));
            if (got.out_last !== want.out_last)
                report($sformatf("out_last got %0b want %0b", got.out_last, want.out_last));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  src_valid = 1'b0;
    logic                  src_stall;
    src_item_t             src_item  = '0;
    logic                  dst_valid;
    logic                  dst_stall = 1'b0;
    dst_item_t             dst_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  steady       = 1'b0;
    int unsigned           quiet_cycles = 0;
    rewrite_scoreboard     sb;

    stream_find_and_replace_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Stall the output side at random outside the steady stretch
    always @(posedge clk)
    begin
        dst_stall <= !steady && ($urandom_range(99) < 10);
    end

    // Check each accepted output transaction
    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
            sb.check_rewrite(dst_item);
    end

    // Watchdog: end the run after too long without any transaction
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** stream_find_and_replace_unit: FAILED **");
            $finish;
        end
    end

    // Offer one source transaction, with a random gap in front, and hold it until taken
    task automatic send_char(input logic [CHAR_BITS-1:0] ch, input logic present,
                             input logic last);
        src_item_t txn;
        txn.in_char      = ch;
        txn.char_present = present;
        txn.string_end   = last;
        while (!steady && $urandom_range(99) < 10)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= txn;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        sb.take_source(txn);
    endtask

    // Release the source and let the block drain before touching registers
    task automatic wait_idle();
        src_valid <= 1'b0;
        while (sb.rewritten_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Write all four registers once the block is idle
    task automatic program_regs(input logic [LEN_W-1:0] klen, input logic [CFG_DATA_W-1:0] kchars,
                                input logic [LEN_W-1:0] rlen, input logic [CFG_DATA_W-1:0] rchars);
        wait_idle();
        write_reg(CFG_KEY_LEN, CFG_DATA_W'(klen));
        write_reg(CFG_KEY_CHARS, kchars);
        write_reg(CFG_REP_LEN, CFG_DATA_W'(rlen));
        write_reg(CFG_REP_CHARS, rchars);
        cfg_valid <= 1'b0;
    endtask

    // One random setting followed by text built mostly from the key and its alphabet
    task automatic run_random_phase(input int unsigned n_chars);
        logic [LEN_W-1:0]      klen;
        logic [LEN_W-1:0]      rlen;
        logic [CFG_DATA_W-1:0] kchars;
        logic [CFG_DATA_W-1:0] rchars;
        logic [CHAR_BITS-1:0]  alpha [3];
        int unsigned           span;
        int unsigned           sent;
        int unsigned           pick;
        case ($urandom_range(9))
            0:       klen = '0;
            1:       klen = LEN_W'($urandom_range(15, REG_CHARS + 1));
            default: klen = LEN_W'($urandom_range(REG_CHARS, 1));
        endcase
        for (int i = 0; i < 3; i++)
            alpha[i] = CHAR_BITS'($urandom_range(255));
        if ($urandom_range(3) == 0)
            kchars = {$urandom, $urandom};
        else
            for (int i = 0; i < REG_CHARS; i++)
                kchars[i*CHAR_BITS +: CHAR_BITS] = alpha[$urandom_range(2)];
        rlen   = LEN_W'($urandom_range(15));
        rchars = {$urandom, $urandom};
        span   = (klen > REG_CHARS) ? REG_CHARS : klen;
        program_regs(klen, kchars, rlen, rchars);

        sent = 0;
        while (sent < n_chars)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                for (int i = 0; i < span; i++)
                    send_char(kchars[i*CHAR_BITS +: CHAR_BITS], 1'b1, 1'b0);
                sent += span;
            end
            else if (pick < 75)
            begin
                send_char(alpha[$urandom_range(2)], 1'b1, 1'b0);
                sent++;
            end
            else if (pick < 85)
            begin
                send_char(CHAR_BITS'($urandom_range(255)), 1'b1, 1'b0);
                sent++;
            end
            else if (pick < 90)
                send_char(CHAR_BITS'($urandom_range(255)), 1'b0, 1'b0);
            else if (pick < 95)
            begin
                send_char(alpha[$urandom_range(2)], 1'b1, 1'b1);
                sent++;
            end
            else
            begin
                send_char(CHAR_BITS'($urandom_range(255)), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: empty key passes text through; idle step; bare ends
        send_char(8'h00, 1'b1, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
        send_char(8'h5A, 1'b0, 1'b0);
        send_char(8'hC3, 1'b0, 1'b1);
        send_char(8'h00, 1'b0, 1'b1);

        // Two-character key, three-character replacement: hits and misses
        program_regs(4'd2, 64'h6261, 4'd3, 64'h5A5958);
        send_char(8'h78, 1'b1, 1'b0);
        send_char(8'h61, 1'b1, 1'b0);
        send_char(8'h62, 1'b1, 1'b0);
        send_char(8'h61, 1'b1, 1'b0);
        send_char(8'h61, 1'b1, 1'b0);
        send_char(8'h62, 1'b1, 1'b0);
        send_char(8'h62, 1'b1, 1'b1);
        send_char(8'hAA, 1'b1, 1'b1);

        // Oversized lengths clamp to eight; leave two characters in the window
        program_regs(4'd15, '1, 4'd15, 64'h00FF_0123_4567_89AB);
        repeat (8) send_char(8'hFF, 1'b1, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);

        // Key shrinks mid-string; zero-valued key deleted by an empty replacement
        program_regs(4'd1, '0, 4'd0, '0);
        send_char(8'h00, 1'b1, 1'b0);
        send_char(8'h00, 1'b1, 1'b1);

        // Random settings, one stretch without any idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            steady <= (p == 3);
            run_random_phase(PHASE_CHARS);
        end
        steady <= 1'b0;
        send_char(CHAR_BITS'($urandom_range(255)), 1'b0, 1'b1);

        wait_idle();
        if (sb.errors == 0)
            $display("** stream_find_and_replace_unit: PASSED **");
        else
            $display("** stream_find_and_replace_unit: FAILED **");
        $finish;
    end

endmodule
